[design/chmc_pkg.sv]
`default_nettype none
package chmc_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // controller to datapath commands
    typedef struct packed {
        logic store;      // write input point at fill count
        logic clr;        // end of set: clear counts and overflow flag
        logic sort_init;  // outer sort index to 1
        logic sort_next;  // read point i, j = i, advance i
        logic sort_key;   // latch key, read point j-1
        logic sort_rd;    // read point j-1
        logic sort_shift; // write read data one place up
        logic sort_put;   // write key at j
        logic hull_init;  // start lower chain
        logic hull_rd;    // read point i of chain
        logic hull_eval;  // register cross product terms
        logic hull_dec;   // pop
        logic hull_push;  // push point
        logic hull_adv;   // next point index
        logic single;     // single point set: stack holds that point
        logic out_init;   // output index to zero
        logic out_rd;     // read stack entry k
        logic out_load;   // load output register
    } chmc_cmd_t;

    typedef struct packed {
        logic sort_done;   // outer index reached n
        logic j_zero;
        logic key_less;
        logic pop_ok;      // pop condition
        logic upper_done;
        logic out_last;
        logic n_small;
        logic n_one;
    } chmc_sts_t;
endpackage
`default_nettype wire

[design/chmc_datapath.sv]
`default_nettype none
module chmc_datapath #(
    parameter int MAX_POINTS = chmc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chmc_pkg::COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire chmc_pkg::chmc_cmd_t          cmd,
    output chmc_pkg::chmc_sts_t               sts,
    input  wire logic signed [COORD_BITS-1:0] in_x,
    input  wire logic signed [COORD_BITS-1:0] in_y,
    output logic signed [COORD_BITS-1:0]      out_x,
    output logic signed [COORD_BITS-1:0]      out_y,
    output logic                              out_dropped
);
    import chmc_pkg::*;
    localparam int PW = $clog2(MAX_POINTS);
    localparam int SD = 2 * MAX_POINTS;
    localparam int SW = $clog2(SD);
    localparam int CW = 2 * COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PRW = 2 * DW;

    logic [CW-1:0] pmem [MAX_POINTS];
    logic [CW-1:0] smem [SD];
    logic [CW-1:0] prd_reg, srd_reg, srd2_reg, key_reg;

    logic [PW:0] cnt_reg, i_reg, j_reg;
    logic [SW:0] top_reg, lim_reg, k_reg;
    logic        ovf_reg, upper_reg;
    logic signed [PRW-1:0] p1_reg, p2_reg;

    logic        full, lower_end, push_ok, prd_en;
    logic [PW:0] prd_addr;
    logic [SW:0] srd_addr, srd2_addr;

    function automatic logic lt(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
        x1 = a[COORD_BITS-1:0]; y1 = a[CW-1:COORD_BITS];
        x2 = b[COORD_BITS-1:0]; y2 = b[CW-1:COORD_BITS];
        return (x1 < x2) || (x1 == x2 && y1 < y2);
    endfunction

    assign full      = (cnt_reg == (PW+1)'(MAX_POINTS));
    assign lower_end = (i_reg == cnt_reg - 1'b1);
    assign push_ok   = cmd.hull_push && (top_reg < (SW+1)'(SD));
    assign prd_en    = cmd.sort_next || cmd.sort_key || cmd.sort_rd || cmd.hull_rd;
    assign srd2_addr = top_reg - (SW+1)'(2);

    // point store port
    always_comb begin
        if (cmd.sort_next || cmd.hull_rd) prd_addr = i_reg;
        else prd_addr = j_reg - 1'b1;
    end
    always_ff @(posedge aclk) begin
        if (cmd.store && !full) pmem[cnt_reg[PW-1:0]] <= {in_y, in_x};
        else if (cmd.sort_shift) pmem[j_reg[PW-1:0]] <= prd_reg;
        else if (cmd.sort_put) pmem[j_reg[PW-1:0]] <= key_reg;
        if (prd_en) prd_reg <= pmem[prd_addr[PW-1:0]];
        if (cmd.sort_key) key_reg <= prd_reg;
    end

    // stack port
    always_comb begin
        if (cmd.out_rd) srd_addr = k_reg;
        else srd_addr = top_reg - 1'b1;
    end
    always_ff @(posedge aclk) begin
        if (push_ok) smem[top_reg[SW-1:0]] <= prd_reg;
        else if (cmd.single) smem[0] <= prd_reg;
        srd_reg  <= smem[srd_addr[SW-1:0]];
        srd2_reg <= smem[srd2_addr[SW-1:0]];
    end

    // cross product, products registered
    logic signed [DW-1:0] ax, ay, bx, by, px, py;
    always_comb begin
        ax = DW'($signed(srd2_reg[COORD_BITS-1:0]));
        ay = DW'($signed(srd2_reg[CW-1:COORD_BITS]));
        bx = DW'($signed(srd_reg[COORD_BITS-1:0]));
        by = DW'($signed(srd_reg[CW-1:COORD_BITS]));
        px = DW'($signed(prd_reg[COORD_BITS-1:0]));
        py = DW'($signed(prd_reg[CW-1:COORD_BITS]));
    end
    logic signed [PRW:0] turn;
    assign turn = (PRW+1)'(p1_reg) - (PRW+1)'(p2_reg);

    always_ff @(posedge aclk) begin
        if (cmd.hull_eval) begin
            p1_reg <= (bx - ax) * (py - ay);
            p2_reg <= (by - ay) * (px - ax);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; ovf_reg <= 1'b0; top_reg <= '0; lim_reg <= '0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0; upper_reg <= 1'b0;
        end else begin
            if (cmd.store) begin
                if (full) ovf_reg <= 1'b1;
                else cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.sort_init) i_reg <= (PW+1)'(1);
            if (cmd.sort_next) begin
                j_reg <= i_reg;
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.sort_shift) j_reg <= j_reg - 1'b1;
            if (cmd.hull_init) begin
                i_reg <= '0; top_reg <= '0; upper_reg <= 1'b0;
            end
            if (cmd.hull_dec) top_reg <= top_reg - 1'b1;
            if (push_ok) top_reg <= top_reg + 1'b1;
            if (cmd.hull_adv) begin
                if (!upper_reg) begin
                    if (lower_end) begin
                        // limit is one above the depth after this push
                        upper_reg <= 1'b1;
                        lim_reg   <= top_reg + (SW+1)'(2);
                        i_reg     <= cnt_reg - (PW+1)'(2);
                    end else i_reg <= i_reg + 1'b1;
                end else i_reg <= i_reg - 1'b1;
            end
            if (cmd.single) top_reg <= (SW+1)'(2);
            if (cmd.out_init) k_reg <= '0;
            if (cmd.out_rd) k_reg <= k_reg + 1'b1;
            if (cmd.clr) begin
                cnt_reg <= '0; ovf_reg <= 1'b0; top_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_x <= srd_reg[COORD_BITS-1:0];
            out_y <= srd_reg[CW-1:COORD_BITS];
            out_dropped <= ovf_reg;
        end
    end

    always_comb begin
        sts.sort_done  = (i_reg >= cnt_reg);
        sts.j_zero     = (j_reg == '0);
        sts.key_less   = lt(key_reg, prd_reg);
        sts.pop_ok     = (turn <= 0) && (upper_reg ? (top_reg >= lim_reg)
                                                   : (top_reg >= (SW+1)'(2)));
        sts.upper_done = upper_reg && (i_reg == '0);
        sts.out_last   = (k_reg == srd2_addr);   // vertex count is depth - 1
        sts.n_small    = (cnt_reg < (PW+1)'(2));
        sts.n_one      = (cnt_reg == (PW+1)'(1));
    end
endmodule
`default_nettype wire

[design/chmc_ctrl.sv]
`default_nettype none
module chmc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_fire,
    input  wire logic                in_last,
    output logic                     in_ready,
    output logic                     out_valid,
    output logic                     out_last,
    input  wire logic                out_ready,
    input  wire chmc_pkg::chmc_sts_t sts,
    output chmc_pkg::chmc_cmd_t      cmd
);
    import chmc_pkg::*;
    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_START = 15'b000000000000010,
        S_SNEXT = 15'b000000000000100,
        S_SKEY  = 15'b000000000001000,
        S_SRD   = 15'b000000000010000,
        S_SCMP  = 15'b000000000100000,
        S_HRD   = 15'b000000001000000,
        S_HTOP  = 15'b000000010000000,
        S_HEVAL = 15'b000000100000000,
        S_HCHK  = 15'b000001000000000,
        S_ONE   = 15'b000010000000000,
        S_ONE2  = 15'b000100000000000,
        S_ORD   = 15'b001000000000000,
        S_OLD   = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } state_t;
    state_t state_reg, state_next;
    logic last_next, last_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_last  = last_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        last_next = last_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.store = 1'b1;
                    if (in_last) state_next = S_START;
                end
            end
            S_START: begin
                // counts now final
                if (sts.n_small) begin
                    if (sts.n_one) begin
                        cmd.hull_init = 1'b1;
                        state_next = S_ONE;
                    end else begin
                        cmd.clr = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.sort_init = 1'b1;
                    state_next = S_SNEXT;
                end
            end
            S_SNEXT: begin
                if (sts.sort_done) begin
                    cmd.hull_init = 1'b1;
                    state_next = S_HRD;
                end else begin
                    cmd.sort_next = 1'b1;
                    state_next = S_SKEY;
                end
            end
            S_SKEY: begin
                cmd.sort_key = 1'b1;
                state_next = S_SCMP;
            end
            S_SRD: begin
                if (sts.j_zero) begin
                    cmd.sort_put = 1'b1;
                    state_next = S_SNEXT;
                end else begin
                    cmd.sort_rd = 1'b1;
                    state_next = S_SCMP;
                end
            end
            S_SCMP: begin
                if (sts.key_less) begin
                    cmd.sort_shift = 1'b1;
                    state_next = S_SRD;
                end else begin
                    cmd.sort_put = 1'b1;
                    state_next = S_SNEXT;
                end
            end
            S_HRD: begin
                // point i and top two stack entries read together
                cmd.hull_rd = 1'b1;
                state_next = S_HEVAL;
            end
            S_HTOP: begin
                // stack reread after a pop
                state_next = S_HEVAL;
            end
            S_HEVAL: begin
                cmd.hull_eval = 1'b1;
                state_next = S_HCHK;
            end
            S_HCHK: begin
                if (sts.pop_ok) begin
                    cmd.hull_dec = 1'b1;
                    state_next = S_HTOP;
                end else begin
                    cmd.hull_push = 1'b1;
                    if (sts.upper_done) begin
                        cmd.out_init = 1'b1;
                        state_next = S_ORD;
                    end else begin
                        cmd.hull_adv = 1'b1;
                        state_next = S_HRD;
                    end
                end
            end
            S_ONE: begin
                cmd.hull_rd = 1'b1;
                state_next = S_ONE2;
            end
            S_ONE2: begin
                cmd.single = 1'b1;
                cmd.out_init = 1'b1;
                state_next = S_ORD;
            end
            S_ORD: begin
                last_next = sts.out_last;
                cmd.out_rd = 1'b1;
                state_next = S_OLD;
            end
            S_OLD: begin
                cmd.out_load = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) begin
                    if (last_reg) begin
                        cmd.clr = 1'b1;
                        state_next = S_IDLE;
                    end else state_next = S_ORD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end
endmodule
`default_nettype wire

[design/convex_hull_monotone_chain_unit.sv]
`default_nettype none
// Convex hull unit (Andrew monotone chain). Points stream in one transaction
// each on s_axis, back to back if wanted; the one with tlast ends the set.
// After the final point the set is insertion sorted in the point store,
// then lower and upper chains are built on a stack memory, with one
// cross-product test per point plus one per pop. The hull goes out
// counter-clockwise from the least point, one vertex per m_axis
// transaction, tlast on the last. A single point comes back as itself.
// Points past MAX_POINTS, the final one included, are dropped and flagged
// in m_axis_tuser on every vertex of that set. Input is blocked from the
// final point of a set until its last vertex is taken.
module convex_hull_monotone_chain_unit #(
    parameter int MAX_POINTS = chmc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chmc_pkg::COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata, // point_x, point_y
    input  wire logic                    s_axis_tlast,   // last_point
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata, // vertex_x, vertex_y
    output logic                         m_axis_tlast,   // last_vertex
    output logic                         m_axis_tuser    // points_dropped
);
    import chmc_pkg::*;
    localparam int TW = ((2*COORD_BITS+7)/8)*8;
    chmc_cmd_t cmd;
    chmc_sts_t sts;
    logic signed [COORD_BITS-1:0] ox, oy;

    chmc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_axis_tvalid && s_axis_tready), .in_last(s_axis_tlast),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
        .out_last(m_axis_tlast), .out_ready(m_axis_tready),
        .sts(sts), .cmd(cmd)
    );

    chmc_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_x(s_axis_tdata[COORD_BITS-1:0]),
        .in_y(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .out_x(ox), .out_y(oy), .out_dropped(m_axis_tuser)
    );

    assign m_axis_tdata = TW'({oy, ox});
endmodule
`default_nettype wire

[design/chmc_checker.sv]
`default_nettype none
module chmc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic s_axis_tlast,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tlast
);
    // no input taken while a result is offered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_axis_tvalid && s_axis_tready)) else $error("input ready during output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
    a_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("ready before set done");
    // set closed: ready drops after the final point is taken
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("ready right after final point");
endmodule
bind convex_hull_monotone_chain_unit chmc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
